// ----- src/assert_macros.svh -----
// Assertion macros shared by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pidf_pkg.sv -----
// Package: constants, codes and saturation helpers of the PIDF controller.
package pidf_pkg;

    localparam int TICK_RATE     = 1000;
    localparam int DESCENT_RATE  = 0;
    localparam int TARGET_RANGE  = 0;
    localparam int FILTER_WEIGHT = 0;

    localparam int CFG_IDX_W = 4;
    localparam int DIV_STEPS = 49;

    // dt = (elapsed << 16) / TICK_RATE as (elapsed * DT_RECIP) >> (32 + DT_SHIFT)
    localparam int DT_SHIFT = $clog2(TICK_RATE);
    localparam logic [79:0] DT_RECIP_W =
        ((80'd1 << (48 + DT_SHIFT)) / 80'(TICK_RATE)) + 80'd1;
    localparam logic [49:0] DT_RECIP = DT_RECIP_W[49:0];

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_F         = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOW     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HIGH    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_RATE      = 4'd7;

    localparam logic [1:0] MODE_STEP    = 2'd0;
    localparam logic [1:0] MODE_SKIP    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    function automatic logic signed [65:0] asr16(input logic signed [65:0] p);
        return {{16{p[65]}}, p[65:16]};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        if (v > 66'sh7FFFFFFFFFFF)
            return 48'sh7FFFFFFFFFFF;
        else if (v < -66'sh800000000000)
            return 48'sh800000000000;
        else
            return v[47:0];
    endfunction

endpackage

// ----- src/pidf_if.sv -----
// Interfaces: request, response and configuration channels.
interface pidf_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] measured;
    logic signed [31:0] target;
    logic [31:0]        stamp;
    modport source (output valid, mode, measured, target, stamp, input ready);
    modport sink (input valid, mode, measured, target, stamp, output ready);
endinterface

interface pidf_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic               fresh;
    modport source (output valid, drive, fresh, input ready);
    modport sink (input valid, drive, fresh, output ready);
endinterface

interface pidf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pidf_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/pidf_controller_step.sv -----
// PIDF controller step: sequencer around one shared multiplier and divider.
// Compute step (past the first, with nonzero elapsed time): reciprocal multiply for
// dt (S_DT_LO, S_DT_HI), one divider pass for error rate, 13 multiply/limit steps.
// Other modes and other steps go from S_DECODE straight to S_FIN. A new request is
// taken only in S_IDLE, once the result is registered; rsp stalls hold it in S_FIN.
// Reset (async, rst_n low) clears registers, state and controller history.
`include "assert_macros.svh"

module pidf_controller_step (
    input logic         clk,
    input logic         rst_n,
    pidf_req_if.sink    req,
    pidf_rsp_if.source  rsp,
    pidf_cfg_if.sink    cfg
);
    import pidf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_DT_LO, S_DT_HI, S_DIV_RT,
        S_M_F, S_M_P, S_M_D, S_M_S, S_M_HI, S_M_I1, S_M_I2, S_M_I3,
        S_M_UP, S_M_DN, S_M_CL, S_M_W1, S_M_W2, S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg, gain_f_reg;
    logic [30:0]        integral_limit_reg, ramp_rate_reg;
    logic signed [31:0] output_low_reg, output_high_reg;

    logic [1:0]         mode_reg, mode_next;
    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] targ_reg, targ_next;
    logic [31:0]        stamp_reg, stamp_next;

    logic signed [47:0] sum_reg, sum_next;
    logic signed [47:0] old_sum_reg, old_sum_next;
    logic signed [31:0] last_error_reg, last_error_next;
    logic signed [31:0] last_drive_reg, last_drive_next;
    logic [31:0]        last_stamp_reg, last_stamp_next;
    logic               first_pass_reg, first_pass_next;

    logic signed [31:0] err_reg, err_next;
    logic [30:0]        dt_reg, dt_next;
    logic               rate_neg_reg, rate_neg_next;
    logic signed [31:0] rate_reg, rate_next;
    logic signed [31:0] ft_reg, ft_next;
    logic signed [31:0] pt_reg, pt_next;
    logic signed [31:0] dtm_reg, dtm_next;
    logic signed [31:0] it_reg, it_next;
    logic signed [31:0] o_reg, o_next;
    logic signed [49:0] up_reg, up_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [65:0] prod_reg, prod_next;

    logic [48:0] div_dvd_reg, div_dvd_next;
    logic [31:0] div_rem_reg, div_rem_next;
    logic [48:0] div_quo_reg, div_quo_next;
    logic [31:0] div_dsr_reg, div_dsr_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;

    logic signed [31:0] res_drive_reg, res_drive_next;
    logic               res_fresh_reg, res_fresh_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_drive_reg, out_drive_next;
    logic               out_fresh_reg, out_fresh_next;

    logic signed [32:0] op_a, op_b;
    logic [32:0]        div_trial;
    logic               div_bit;
    logic [31:0]        div_rem_step;
    logic [48:0]        div_quo_step;

    always_comb
    begin
        logic signed [31:0] err_v;
        logic [31:0]        elapsed;
        logic [30:0]        dt_v;
        logic signed [65:0] dt_sum;
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic signed [33:0] sp_v, sp_lo, sp_hi;
        logic signed [31:0] it_v;
        logic signed [32:0] lim_pos, lim_neg, it_w;
        logic signed [49:0] dn_v, ld_v, lo_v, hi_v, ov, cv;
        logic signed [31:0] fin_v;

        state_next      = state_reg;
        mode_next       = mode_reg;
        meas_next       = meas_reg;
        targ_next       = targ_reg;
        stamp_next      = stamp_reg;
        sum_next        = sum_reg;
        old_sum_next    = old_sum_reg;
        last_error_next = last_error_reg;
        last_drive_next = last_drive_reg;
        last_stamp_next = last_stamp_reg;
        first_pass_next = first_pass_reg;
        err_next        = err_reg;
        dt_next         = dt_reg;
        rate_neg_next   = rate_neg_reg;
        rate_next       = rate_reg;
        ft_next         = ft_reg;
        pt_next         = pt_reg;
        dtm_next        = dtm_reg;
        it_next         = it_reg;
        o_next          = o_reg;
        up_next         = up_reg;
        acc_next        = acc_reg;
        div_dvd_next    = div_dvd_reg;
        div_rem_next    = div_rem_reg;
        div_quo_next    = div_quo_reg;
        div_dsr_next    = div_dsr_reg;
        div_cnt_next    = div_cnt_reg;
        res_drive_next  = res_drive_reg;
        res_fresh_next  = res_fresh_reg;
        out_valid_next  = out_valid_reg;
        out_drive_next  = out_drive_reg;
        out_fresh_next  = out_fresh_reg;
        op_a            = '0;
        op_b            = '0;

        err_v   = sat32(66'(targ_reg) - 66'(meas_reg));
        elapsed = stamp_reg - last_stamp_reg;
        dt_v    = dt_reg;
        dt_sum  = '0;
        diff    = '0;
        mag     = '0;
        sp_v    = 34'(targ_reg);
        sp_lo   = 34'(meas_reg) - 34'(TARGET_RANGE);
        sp_hi   = 34'(meas_reg) + 34'(TARGET_RANGE);
        it_v    = '0;
        lim_pos = $signed({2'b00, integral_limit_reg});
        lim_neg = -lim_pos;
        it_w    = '0;
        dn_v    = '0;
        ld_v    = 50'(last_drive_reg);
        lo_v    = '0;
        hi_v    = '0;
        ov      = 50'(o_reg);
        cv      = '0;
        fin_v   = o_reg;

        div_trial    = {div_rem_reg, div_dvd_reg[48]};
        div_bit      = div_trial >= {1'b0, div_dsr_reg};
        div_rem_step = div_bit ? 32'(div_trial - {1'b0, div_dsr_reg}) : div_trial[31:0];
        div_quo_step = {div_quo_reg[47:0], div_bit};

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = req.mode;
                    meas_next  = req.measured;
                    targ_next  = req.target;
                    stamp_next = req.stamp;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_drive_next = last_drive_reg;
                res_fresh_next = 1'b0;
                state_next     = S_FIN;
                unique case (mode_reg)
                    MODE_SKIP:
                        last_stamp_next = stamp_reg;
                    MODE_RESTART:
                    begin
                        first_pass_next = 1'b1;
                        sum_next        = '0;
                    end
                    MODE_STEP:
                    begin
                        err_next = err_v;
                        if (first_pass_reg)
                        begin
                            last_error_next = err_v;
                            last_drive_next = '0;
                            last_stamp_next = stamp_reg;
                            first_pass_next = 1'b0;
                            res_drive_next  = '0;
                        end
                        else if (elapsed != 32'd0)
                        begin
                            op_a       = $signed({1'b0, elapsed});
                            op_b       = $signed({1'b0, DT_RECIP[31:0]});
                            state_next = S_DT_LO;
                        end
                    end
                    default:
                        res_fresh_next = 1'b0;
                endcase
            end
            S_DT_LO:
            begin
                acc_next   = prod_reg;
                op_a       = $signed({1'b0, elapsed});
                op_b       = $signed({15'd0, DT_RECIP[49:32]});
                state_next = S_DT_HI;
            end
            S_DT_HI:
            begin
                dt_sum = (prod_reg + (acc_reg >>> 32)) >>> DT_SHIFT;
                if (dt_sum == 66'sd0)
                    dt_v = 31'd1;
                else if (dt_sum > 66'sh7FFFFFFF)
                    dt_v = 31'h7FFFFFFF;
                else
                    dt_v = dt_sum[30:0];
                dt_next       = dt_v;
                diff          = 33'(err_reg) - 33'(last_error_reg);
                mag           = diff[32] ? 33'(-diff) : 33'(diff);
                rate_neg_next = diff[32];
                div_dvd_next  = {mag[32:0], 16'd0};
                div_rem_next  = '0;
                div_quo_next  = '0;
                div_dsr_next  = {1'b0, dt_v};
                div_cnt_next  = 6'(DIV_STEPS - 1);
                state_next    = S_DIV_RT;
            end
            S_DIV_RT:
            begin
                div_dvd_next = {div_dvd_reg[47:0], 1'b0};
                div_rem_next = div_rem_step;
                div_quo_next = div_quo_step;
                div_cnt_next = div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd0)
                begin
                    if (rate_neg_reg)
                        rate_next = (div_quo_step > 49'h80000000) ? 32'sh80000000
                                                                  : 32'(-div_quo_step);
                    else
                        rate_next = (div_quo_step > 49'h7FFFFFFF) ? 32'sh7FFFFFFF
                                                                  : div_quo_step[31:0];
                    state_next = S_M_F;
                end
            end
            S_M_F:
            begin
                if (TARGET_RANGE != 0)
                begin
                    if (sp_v > sp_hi)
                        sp_v = sp_hi;
                    else if (sp_v < sp_lo)
                        sp_v = sp_lo;
                end
                op_a       = 33'(gain_f_reg);
                op_b       = 33'(sp_v);
                state_next = S_M_P;
            end
            S_M_P:
            begin
                ft_next    = sat32(asr16(prod_reg));
                op_a       = 33'(gain_p_reg);
                op_b       = 33'(err_reg);
                state_next = S_M_D;
            end
            S_M_D:
            begin
                pt_next    = sat32(asr16(prod_reg));
                op_a       = 33'(gain_d_reg);
                op_b       = 33'(rate_reg);
                state_next = S_M_S;
            end
            S_M_S:
            begin
                dtm_next   = sat32(asr16(prod_reg));
                op_a       = 33'(err_reg);
                op_b       = $signed({2'b00, dt_reg});
                state_next = S_M_HI;
            end
            S_M_HI:
            begin
                old_sum_next = sum_reg;
                sum_next     = sat48(66'(sum_reg) + asr16(prod_reg));
                state_next   = S_M_I1;
            end
            S_M_I1:
            begin
                op_a       = 33'(gain_i_reg);
                op_b       = 33'($signed(sum_reg[47:16]));
                state_next = S_M_I2;
            end
            S_M_I2:
            begin
                acc_next   = prod_reg;
                op_a       = 33'(gain_i_reg);
                op_b       = $signed({17'd0, sum_reg[15:0]});
                state_next = S_M_I3;
            end
            S_M_I3:
            begin
                it_v = sat32(acc_reg + asr16(prod_reg));
                it_w = 33'(it_v);
                if (integral_limit_reg != 31'd0 && !(it_w > lim_neg && it_w < lim_pos))
                begin
                    if (it_w > lim_pos)
                        it_v = lim_pos[31:0];
                    else if (it_w < lim_neg)
                        it_v = lim_neg[31:0];
                    sum_next = old_sum_reg;
                end
                it_next    = it_v;
                op_a       = $signed({2'b00, ramp_rate_reg});
                op_b       = $signed({2'b00, dt_reg});
                state_next = S_M_UP;
            end
            S_M_UP:
            begin
                o_next     = sat32(66'(ft_reg) + 66'(pt_reg) + 66'(it_reg) + 66'(dtm_reg));
                up_next    = 50'(asr16(prod_reg));
                op_a       = 33'(DESCENT_RATE);
                op_b       = $signed({2'b00, dt_reg});
                state_next = S_M_DN;
            end
            S_M_DN:
            begin
                if (ramp_rate_reg != 31'd0 && DESCENT_RATE != 0)
                begin
                    dn_v = 50'(asr16(prod_reg));
                    if (last_drive_reg > 32'sd0)
                    begin
                        lo_v = ld_v + dn_v;
                        hi_v = ld_v + up_reg;
                    end
                    else
                    begin
                        lo_v = ld_v - up_reg;
                        hi_v = ld_v - dn_v;
                    end
                    if (!(ov > lo_v && ov < hi_v))
                    begin
                        if (ov > hi_v)
                            cv = hi_v;
                        else if (ov < lo_v)
                            cv = lo_v;
                        else
                            cv = ov;
                        o_next   = sat32(66'(cv));
                        sum_next = old_sum_reg;
                    end
                end
                state_next = S_M_CL;
            end
            S_M_CL:
            begin
                if (output_low_reg != output_high_reg &&
                    !(o_reg > output_low_reg && o_reg < output_high_reg))
                begin
                    if (o_reg > output_high_reg)
                        o_next = output_high_reg;
                    else if (o_reg < output_low_reg)
                        o_next = output_low_reg;
                    sum_next = old_sum_reg;
                end
                op_a       = 33'(last_drive_reg);
                op_b       = 33'(FILTER_WEIGHT);
                state_next = S_M_W1;
            end
            S_M_W1:
            begin
                acc_next   = prod_reg;
                op_a       = 33'(o_reg);
                op_b       = 33'(65536 - FILTER_WEIGHT);
                state_next = S_M_W2;
            end
            S_M_W2:
            begin
                if (FILTER_WEIGHT != 0)
                    fin_v = 32'(asr16(acc_reg + prod_reg));
                last_drive_next = fin_v;
                last_stamp_next = stamp_reg;
                last_error_next = err_reg;
                res_drive_next  = fin_v;
                res_fresh_next  = 1'b1;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_drive_next = res_drive_reg;
                    out_fresh_next = res_fresh_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        prod_next = 66'(op_a * op_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            gain_f_reg         <= '0;
            integral_limit_reg <= '0;
            output_low_reg     <= '0;
            output_high_reg    <= '0;
            ramp_rate_reg      <= '0;
            mode_reg           <= '0;
            meas_reg           <= '0;
            targ_reg           <= '0;
            stamp_reg          <= '0;
            sum_reg            <= '0;
            old_sum_reg        <= '0;
            last_error_reg     <= '0;
            last_drive_reg     <= '0;
            last_stamp_reg     <= '0;
            first_pass_reg     <= 1'b1;
            err_reg            <= '0;
            dt_reg             <= '0;
            rate_neg_reg       <= 1'b0;
            rate_reg           <= '0;
            ft_reg             <= '0;
            pt_reg             <= '0;
            dtm_reg            <= '0;
            it_reg             <= '0;
            o_reg              <= '0;
            up_reg             <= '0;
            acc_reg            <= '0;
            prod_reg           <= '0;
            div_dvd_reg        <= '0;
            div_rem_reg        <= '0;
            div_quo_reg        <= '0;
            div_dsr_reg        <= '0;
            div_cnt_reg        <= '0;
            res_drive_reg      <= '0;
            res_fresh_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_drive_reg      <= '0;
            out_fresh_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            meas_reg       <= meas_next;
            targ_reg       <= targ_next;
            stamp_reg      <= stamp_next;
            sum_reg        <= sum_next;
            old_sum_reg    <= old_sum_next;
            last_error_reg <= last_error_next;
            last_drive_reg <= last_drive_next;
            last_stamp_reg <= last_stamp_next;
            first_pass_reg <= first_pass_next;
            err_reg        <= err_next;
            dt_reg         <= dt_next;
            rate_neg_reg   <= rate_neg_next;
            rate_reg       <= rate_next;
            ft_reg         <= ft_next;
            pt_reg         <= pt_next;
            dtm_reg        <= dtm_next;
            it_reg         <= it_next;
            o_reg          <= o_next;
            up_reg         <= up_next;
            acc_reg        <= acc_next;
            prod_reg       <= prod_next;
            div_dvd_reg    <= div_dvd_next;
            div_rem_reg    <= div_rem_next;
            div_quo_reg    <= div_quo_next;
            div_dsr_reg    <= div_dsr_next;
            div_cnt_reg    <= div_cnt_next;
            res_drive_reg  <= res_drive_next;
            res_fresh_reg  <= res_fresh_next;
            out_valid_reg  <= out_valid_next;
            out_drive_reg  <= out_drive_next;
            out_fresh_reg  <= out_fresh_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_GAIN_P:         gain_p_reg         <= cfg.data;
                    REG_GAIN_I:         gain_i_reg         <= cfg.data;
                    REG_GAIN_D:         gain_d_reg         <= cfg.data;
                    REG_GAIN_F:         gain_f_reg         <= cfg.data;
                    REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg.data[30:0];
                    REG_OUTPUT_LOW:     output_low_reg     <= cfg.data;
                    REG_OUTPUT_HIGH:    output_high_reg    <= cfg.data;
                    REG_RAMP_RATE:      ramp_rate_reg      <= cfg.data[30:0];
                    default:            gain_p_reg         <= gain_p_reg;
                endcase
            end
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.drive = out_drive_reg;
    assign rsp.fresh = out_fresh_reg;
    assign cfg.ready = 1'b1;

    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, req.valid && req.ready, !req.ready && state_reg == S_DECODE, "request taken while busy")
    `ASSERT_IMPLY(a_fresh_has_dt, clk, rst_n, state_reg == S_FIN && res_fresh_reg, dt_reg != 31'd0, "fresh result without valid dt")
    `ASSERT_NEXT(a_div_holds, clk, rst_n, state_reg == S_DIV_RT && div_cnt_reg != 6'd0, state_reg == S_DIV_RT, "rate division left early")

endmodule
